[sv/ghpf_pkg.sv]
package ghpf_pkg;

    localparam int CoordW   = 31;   // fix coordinates
    localparam int DeltaW   = 32;   // displacement
    localparam int SqW      = 64;   // squared distance
    localparam int CordW    = 35;   // CORDIC x/y, covers the gain on a 2^31 vector
    localparam int AngW     = 25;   // angle in 1/256 centidegree
    localparam int HeadW    = 16;
    localparam int SpeedW   = 16;
    localparam int LimW     = 15;
    localparam int TravelW  = 16;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    localparam int CordicSteps = 20;
    localparam int StepW       = $clog2(CordicSteps);

    localparam logic signed [AngW-1:0]  AngBase180 = AngW'(4608000);
    localparam logic        [CordW-1:0] NormLimit  = CordW'(64'd1 << 30);
    localparam logic        [14:0]      HeadMax    = 15'd18000;

    localparam logic [CfgIdxW-1:0] CFG_MIN_LINEAR_SPEED = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_TURN_RATE    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIN_TRAVEL       = 2'd2;

    localparam logic [LimW-1:0]    MinSpeedReset  = 15'd200;
    localparam logic [LimW-1:0]    MaxRateReset   = 15'd100;
    localparam logic [TravelW-1:0] MinTravelReset = 16'd50;

    typedef enum logic [1:0] {
        MUL_DX     = 2'd0,
        MUL_DY     = 2'd1,
        MUL_TRAVEL = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic             capture;
        logic             store_fix;
        logic             ld_delta;
        logic             mul_en;
        mul_sel_t         mul_sel;
        logic             acc_load;
        logic             acc_add;
        logic             cordic_init;
        logic             norm_step;
        logic             rot_step;
        logic [StepW-1:0] step;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic gate_ok;
        logic prev_valid;
        logic d2_gt;
        logic norm_done;
        logic out_busy;
    } sts_t;

    // atan(2^-i) in 1/256 centidegree
    function automatic logic [20:0] atan_step(input logic [StepW-1:0] i);
        logic [20:0] v;
        case (i)
            5'd0:    v = 21'd1152000;
            5'd1:    v = 21'd680065;
            5'd2:    v = 21'd359328;
            5'd3:    v = 21'd182400;
            5'd4:    v = 21'd91554;
            5'd5:    v = 21'd45822;
            5'd6:    v = 21'd22916;
            5'd7:    v = 21'd11459;
            5'd8:    v = 21'd5730;
            5'd9:    v = 21'd2865;
            5'd10:   v = 21'd1432;
            5'd11:   v = 21'd716;
            5'd12:   v = 21'd358;
            5'd13:   v = 21'd179;
            5'd14:   v = 21'd90;
            5'd15:   v = 21'd45;
            5'd16:   v = 21'd22;
            5'd17:   v = 21'd11;
            5'd18:   v = 21'd6;
            5'd19:   v = 21'd3;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

[sv/ghpf_ctrl.sv]
module ghpf_ctrl
    import ghpf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic func,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_SQX   = 10'b0000000100,
        S_SQY   = 10'b0000001000,
        S_SQT   = 10'b0000010000,
        S_CMP   = 10'b0000100000,
        S_INIT  = 10'b0001000000,
        S_NORM  = 10'b0010000000,
        S_ROT   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        cmd             = '0;
        cmd.mul_sel     = MUL_DX;
        cmd.step        = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = accept;
                if (accept && func)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!sts.gate_ok)
                    state_next = S_IDLE;
                else if (!sts.prev_valid)
                begin
                    cmd.store_fix = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.store_fix = 1'b1;
                    cmd.ld_delta  = 1'b1;
                    state_next    = S_SQX;
                end
            end
            S_SQX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DX;
                state_next  = S_SQY;
            end
            S_SQY:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_DY;
                cmd.acc_load = 1'b1;
                state_next   = S_SQT;
            end
            S_SQT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TRAVEL;
                cmd.acc_add = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                state_next = sts.d2_gt ? S_INIT : S_IDLE;
            end
            S_INIT:
            begin
                cmd.cordic_init = 1'b1;
                state_next      = S_NORM;
            end
            S_NORM:
            begin
                if (sts.norm_done)
                begin
                    step_next  = '0;
                    state_next = S_ROT;
                end
                else
                    cmd.norm_step = 1'b1;
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (step_reg == StepW'(CordicSteps - 1))
                    state_next = S_OUT;
                else
                    step_next = step_reg + 1'b1;
            end
            S_OUT:
            begin
                // hold until the output register can take the beat
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

[sv/ghpf_dp.sv]
module ghpf_dp
    import ghpf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic                      func,
    input  logic signed [SpeedW-1:0]  linear_speed,
    input  logic signed [SpeedW-1:0]  turn_rate,
    input  logic signed [CoordW-1:0]  pos_x,
    input  logic signed [CoordW-1:0]  pos_y,
    input  logic                      cfg_we,
    input  logic [CfgIdxW-1:0]        cfg_index,
    input  logic [CfgDataW-1:0]       cfg_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [HeadW-1:0]   heading_centideg
);

    logic [LimW-1:0]            min_speed_reg;
    logic [LimW-1:0]            max_rate_reg;
    logic [TravelW-1:0]         min_travel_reg;
    logic signed [SpeedW-1:0]   speed_reg;
    logic signed [SpeedW-1:0]   rate_reg;
    logic signed [CoordW-1:0]   fix_x_reg, fix_y_reg;
    logic signed [CoordW-1:0]   prev_x_reg, prev_y_reg;
    logic                       prev_valid_reg;
    logic signed [DeltaW-1:0]   dx_reg, dy_reg;
    logic [SqW-1:0]             prod_reg, acc_reg;
    logic signed [CordW-1:0]    x_reg, y_reg;
    logic signed [AngW-1:0]     z_reg;
    logic                       out_valid_reg;
    logic signed [HeadW-1:0]    heading_reg;

    // gate
    logic signed [SpeedW:0]     rate_ext;
    logic [SpeedW:0]            rate_abs;
    logic                       speed_ok, rate_ok;

    assign rate_ext = {rate_reg[SpeedW-1], rate_reg};
    assign rate_abs = rate_ext[SpeedW] ? unsigned'(-rate_ext) : unsigned'(rate_ext);
    assign speed_ok = $signed({speed_reg[SpeedW-1], speed_reg})
                      > $signed({2'b00, min_speed_reg});
    assign rate_ok  = rate_abs < {2'b00, max_rate_reg};

    // displacement
    logic signed [DeltaW-1:0] dx_next, dy_next;
    assign dx_next = {fix_x_reg[CoordW-1], fix_x_reg} - {prev_x_reg[CoordW-1], prev_x_reg};
    assign dy_next = {fix_y_reg[CoordW-1], fix_y_reg} - {prev_y_reg[CoordW-1], prev_y_reg};

    // shared squarer
    logic signed [DeltaW-1:0] mul_a;
    logic signed [SqW-1:0]    sq;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DX:     mul_a = dx_reg;
            MUL_DY:     mul_a = dy_reg;
            MUL_TRAVEL: mul_a = {{(DeltaW-TravelW){1'b0}}, min_travel_reg};
            default:    mul_a = dx_reg;
        endcase
    end

    assign sq = mul_a * mul_a;

    // CORDIC
    logic [CordW-1:0]        x_abs, y_abs;
    logic signed [CordW-1:0] sx, sy;
    logic signed [AngW-1:0]  at;
    logic                    y_pos;

    assign x_abs = x_reg[CordW-1] ? unsigned'(-x_reg) : unsigned'(x_reg);
    assign y_abs = y_reg[CordW-1] ? unsigned'(-y_reg) : unsigned'(y_reg);
    assign sx    = x_reg >>> cmd.step;
    assign sy    = y_reg >>> cmd.step;
    assign at    = signed'({{(AngW-21){1'b0}}, atan_step(cmd.step)});
    assign y_pos = !y_reg[CordW-1] && (|y_reg);

    // rounding to centidegrees, ties away from zero
    logic [AngW-1:0] z_abs, z_rnd;
    logic [16:0]     r_mag;
    logic [14:0]     r_clamp;
    logic [HeadW-1:0] r_pos;

    assign z_abs   = z_reg[AngW-1] ? unsigned'(-z_reg) : unsigned'(z_reg);
    assign z_rnd   = z_abs + AngW'(128);
    assign r_mag   = z_rnd[AngW-1:8];
    assign r_clamp = (r_mag > {2'b00, HeadMax}) ? HeadMax : r_mag[14:0];
    assign r_pos   = {1'b0, r_clamp};

    assign sts.gate_ok    = speed_ok && rate_ok;
    assign sts.prev_valid = prev_valid_reg;
    assign sts.d2_gt      = acc_reg > prod_reg;
    assign sts.norm_done  = (x_abs >= NormLimit) || (y_abs >= NormLimit);
    assign sts.out_busy   = out_valid_reg && out_stall;

    assign out_valid        = out_valid_reg;
    assign heading_centideg = heading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg  <= MinSpeedReset;
            max_rate_reg   <= MaxRateReset;
            min_travel_reg <= MinTravelReset;
            speed_reg      <= '0;
            rate_reg       <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_LINEAR_SPEED: min_speed_reg  <= cfg_data[LimW-1:0];
                    CFG_MAX_TURN_RATE:    max_rate_reg   <= cfg_data[LimW-1:0];
                    CFG_MIN_TRAVEL:       min_travel_reg <= cfg_data[TravelW-1:0];
                    default:              ;
                endcase
            end
            if (cmd.capture && !func)
            begin
                speed_reg <= linear_speed;
                rate_reg  <= turn_rate;
            end
            if (cmd.store_fix)
            begin
                prev_x_reg     <= fix_x_reg;
                prev_y_reg     <= fix_y_reg;
                prev_valid_reg <= 1'b1;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && func)
        begin
            fix_x_reg <= pos_x;
            fix_y_reg <= pos_y;
        end
        if (cmd.ld_delta)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (cmd.mul_en)
            prod_reg <= unsigned'(sq);
        if (cmd.acc_load)
            acc_reg <= prod_reg;
        else if (cmd.acc_add)
            acc_reg <= acc_reg + prod_reg;

        if (cmd.cordic_init)
        begin
            // left half-plane: negate and start from +/-180 degrees
            if (dx_reg[DeltaW-1])
            begin
                x_reg <= -CordW'(dx_reg);
                y_reg <= -CordW'(dy_reg);
                z_reg <= dy_reg[DeltaW-1] ? -AngBase180 : AngBase180;
            end
            else
            begin
                x_reg <= CordW'(dx_reg);
                y_reg <= CordW'(dy_reg);
                z_reg <= '0;
            end
        end
        else if (cmd.norm_step)
        begin
            x_reg <= x_reg <<< 1;
            y_reg <= y_reg <<< 1;
        end
        else if (cmd.rot_step)
        begin
            if (y_pos)
            begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - at;
            end
        end

        if (cmd.load_out)
            heading_reg <= z_reg[AngW-1] ? -signed'(r_pos) : signed'(r_pos);
    end

endmodule

[sv/gated_heading_from_position_fixes.sv]
// Heading from successive position fixes, gated by odometry.
// Input channel (in_valid/in_stall): func = 0 carries linear_speed and turn_rate,
// func = 1 carries a fix in pos_x/pos_y. A beat moves when in_valid is high and
// in_stall is low. Output channel (out_valid/out_stall) carries heading_centideg.
// Config channel (cfg_valid/cfg_ready, cfg_ready always high): index 0 min linear
// speed, 1 max turn rate, 2 min travel; other indexes are dropped. Write only idle.
// Per beat: odometry is taken in idle; a fix with the gate closed or no previous
// fix ends after the check state; one with too short a displacement after the
// squares and the compare; one giving a heading goes on through init, 0..30
// single-bit normalization shifts that bring the larger displacement component
// up to 2^30, 20 steps of one shift-add CORDIC unit and the output state, which
// waits for a free output register. Squares use one shared 32x32 squarer. The
// next input beat can be taken in the same cycle the heading shows at the output.
// A held result does not block a new input beat; only a second heading waits
// for the output register to drain while out_stall is high.
// Reset clears the odometry values, the previous fix and out_valid, and loads
// the threshold registers with 200, 100 and 50.
module gated_heading_from_position_fixes
    import ghpf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic signed [SpeedW-1:0]  linear_speed,
    input  logic signed [SpeedW-1:0]  turn_rate,
    input  logic signed [CoordW-1:0]  pos_x,
    input  logic signed [CoordW-1:0]  pos_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [HeadW-1:0]   heading_centideg,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CfgIdxW-1:0]        cfg_index,
    input  logic [CfgDataW-1:0]       cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    ghpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .sts      (sts),
        .cmd      (cmd)
    );

    ghpf_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .func             (func),
        .linear_speed     (linear_speed),
        .turn_rate        (turn_rate),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .heading_centideg (heading_centideg)
    );

endmodule
